// ===== rtl/v3n_pkg.sv =====
`default_nettype none
package v3n_pkg;

  // operation code carried by each input beat
  typedef logic [2:0] kind_t;

  localparam kind_t KIND_ADD   = 3'd0;
  localparam kind_t KIND_SUB   = 3'd1;
  localparam kind_t KIND_MUL   = 3'd2;
  localparam kind_t KIND_SCALE = 3'd3;
  localparam kind_t KIND_CROSS = 3'd4;
  localparam kind_t KIND_NORM  = 3'd5;

endpackage
`default_nettype wire

// ===== rtl/v3n_sqrt_pipe.sv =====
`default_nettype none
module v3n_sqrt_pipe #(
  parameter int W      = 32,
  parameter int SIDE_W = 98
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*W-1:0]    in_n,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [W-1:0]           out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int RW = W + 3;
  localparam int SQW = 2 * W + 2;

  logic [RW-1:0]     rem_r  [W];
  logic [W-1:0]      root_r [W];
  logic [2*W-1:0]    n_r    [W];
  logic              v_r    [W];
  logic [SIDE_W-1:0] side_r [W];

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RW-1:0]     rem_i;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic [W-1:0]      root_i;
    logic [2*W-1:0]    n_i;
    logic              v_i;
    logic [SIDE_W-1:0] side_i;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = in_n;
      assign v_i    = in_valid;
      assign side_i = in_side;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign n_i    = n_r[k-1];
      assign v_i    = v_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign rem_sh = {rem_i[RW-3:0], n_i[2*(W-1-k)+1 -: 2]};
    assign trial  = RW'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_i;
        side_r[k] <= side_i;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_i[W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_i[W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign out_root  = root_r[W-1];
  assign out_side  = side_r[W-1];

  // root is the floor of the square root
  logic [SQW-1:0] root_ext;
  logic [SQW-1:0] sq_lo;
  logic [SQW-1:0] sq_hi;
  assign root_ext = SQW'(out_root);
  assign sq_lo    = root_ext * root_ext;
  assign sq_hi    = (root_ext + SQW'(1)) * (root_ext + SQW'(1));

  a_root_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sq_lo <= SQW'(n_r[W-1])))
    else $error("root squared exceeds radicand");

  a_root_high : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sq_hi > SQW'(n_r[W-1])))
    else $error("root one too small");

endmodule
`default_nettype wire

// ===== rtl/v3n_recip_pipe.sv =====
`default_nettype none
module v3n_recip_pipe #(
  parameter int W      = 32,
  parameter int F      = 16,
  parameter int SIDE_W = 98
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [W-1:0]      in_len,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [2*F:0]           out_q,
  output logic [W-1:0]           out_len,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int Q  = 2 * F + 1;
  localparam int QW = Q + W + 1;
  localparam logic [QW-1:0] DIVIDEND = QW'(1) << (2 * F);

  logic [W:0]        rem_r  [Q];
  logic [Q-1:0]      q_r    [Q];
  logic [W-1:0]      len_r  [Q];
  logic              v_r    [Q];
  logic [SIDE_W-1:0] side_r [Q];

  // one quotient bit per stage of 2^(2F) / len
  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [W:0]        rem_i;
    logic [W:0]        rem_sh;
    logic [W:0]        dv;
    logic [Q-1:0]      q_i;
    logic [W-1:0]      len_i;
    logic              v_i;
    logic [SIDE_W-1:0] side_i;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign q_i    = '0;
      assign len_i  = in_len;
      assign v_i    = in_valid;
      assign side_i = in_side;
      assign rem_sh = {rem_i[W-1:0], 1'b1};
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign q_i    = q_r[k-1];
      assign len_i  = len_r[k-1];
      assign v_i    = v_r[k-1];
      assign side_i = side_r[k-1];
      assign rem_sh = {rem_i[W-1:0], 1'b0};
    end

    assign dv = {1'b0, len_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k]  <= len_i;
        side_r[k] <= side_i;
        if (rem_sh >= dv) begin
          rem_r[k] <= rem_sh - dv;
          q_r[k]   <= {q_i[Q-2:0], 1'b1};
        end else begin
          rem_r[k] <= rem_sh;
          q_r[k]   <= {q_i[Q-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[Q-1];
  assign out_q     = q_r[Q-1];
  assign out_len   = len_r[Q-1];
  assign out_side  = side_r[Q-1];

  // quotient is the floor for any nonzero divisor
  logic [QW-1:0] prod_lo;
  logic [QW-1:0] prod_hi;
  assign prod_lo = QW'(out_q) * QW'(out_len);
  assign prod_hi = prod_lo + QW'(out_len);

  a_quot_floor : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_len != '0)) |-> ((prod_lo <= DIVIDEND) && (prod_hi > DIVIDEND)))
    else $error("reciprocal quotient off");

endmodule
`default_nettype wire

// ===== rtl/vector3_alu_with_normalize_unit.sv =====
`default_nettype none
// three-component vector unit, signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction)
// input channel: in_valid / in_stall carry kind, vectors a and b and a scalar per beat
// kinds: add, sub, element-wise mul, scale, cross a x b, normalize a; others give zero
// output channel: out_valid / out_stall carry r_x, r_y, r_z and the overflow flag
// one result beat per input beat, in order
// throughput: one beat per cycle while the output beat is not held, any kind mixed freely
// every beat passes through the input, product and rescale stages, the square-root
//   pipeline (one root bit per stage), the reciprocal divider (one quotient bit per
//   stage), the multiply stage and the output register, which keeps beats in order
// products are truncated toward minus infinity; results saturate to DATA_WIDTH bits
// normalize of an all-zero vector returns zero with overflow clear
// reset: synchronous, active low; clears every stage valid bit, no result pending
// stall: when the output beat is held, the whole pipeline freezes and in_stall rises
//   in the same cycle; nothing is lost or repeated
module vector3_alu_with_normalize_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire v3n_pkg::kind_t               in_kind,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_z,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_z,
  input  wire logic signed [DATA_WIDTH-1:0] in_scale,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_r_x,
  output logic signed [DATA_WIDTH-1:0]      out_r_y,
  output logic signed [DATA_WIDTH-1:0]      out_r_z,
  output logic                              out_overflow
);

  import v3n_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int PW     = 2 * W;
  localparam int XW     = 2 * W + 2;
  localparam int Q      = 2 * F + 1;
  localparam int MW     = W + Q + 1;
  localparam int SW     = (XW > MW) ? XW : MW;
  localparam int SIDE_W = 3 * W + 2;
  localparam logic signed [SW-1:0] SAT_HI = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  // returns {saturated, value}
  function automatic logic [W:0] sat_f(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[W-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic en;
  logic out_valid_r;

  // whole pipeline moves unless the output beat is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage 1: input register
  logic                s1_v_r;
  kind_t               s1_kind_r;
  logic signed [W-1:0] s1_a_r [3];
  logic signed [W-1:0] s1_b_r [3];
  logic signed [W-1:0] s1_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= in_kind;
      s1_a_r[0] <= in_a_x;
      s1_a_r[1] <= in_a_y;
      s1_a_r[2] <= in_a_z;
      s1_b_r[0] <= in_b_x;
      s1_b_r[1] <= in_b_y;
      s1_b_r[2] <= in_b_z;
      s1_s_r    <= in_scale;
    end
  end

  // stage 2: products and sums
  logic                 s2_v_r;
  kind_t                s2_kind_r;
  logic signed [W-1:0]  s2_a_r  [3];
  logic signed [PW-1:0] s2_p0_r [3];
  logic signed [PW-1:0] s2_p1_r [3];
  logic signed [W:0]    s2_as_r [3];
  logic signed [PW-1:0] s2_p0_nxt [3];
  logic signed [PW-1:0] s2_p1_nxt [3];
  logic signed [W:0]    s2_as_nxt [3];

  always_comb begin
    logic signed [W-1:0] op0;
    logic signed [W-1:0] op1;
    for (int i = 0; i < 3; i++) begin
      op0 = s1_a_r[i];
      op1 = s1_b_r[i];
      case (s1_kind_r)
        KIND_SCALE: op1 = s1_s_r;
        KIND_CROSS: begin
          op0 = s1_a_r[(i+1)%3];
          op1 = s1_b_r[(i+2)%3];
        end
        KIND_NORM:  op1 = s1_a_r[i];
        default:    op1 = s1_b_r[i];
      endcase
      s2_p0_nxt[i] = PW'(op0) * PW'(op1);
      s2_p1_nxt[i] = PW'(s1_a_r[(i+2)%3]) * PW'(s1_b_r[(i+1)%3]);
      if (s1_kind_r == KIND_SUB) begin
        s2_as_nxt[i] = (W+1)'(s1_a_r[i]) - (W+1)'(s1_b_r[i]);
      end else begin
        s2_as_nxt[i] = (W+1)'(s1_a_r[i]) + (W+1)'(s1_b_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r <= s1_kind_r;
      for (int i = 0; i < 3; i++) begin
        s2_a_r[i]  <= s1_a_r[i];
        s2_p0_r[i] <= s2_p0_nxt[i];
        s2_p1_r[i] <= s2_p1_nxt[i];
        s2_as_r[i] <= s2_as_nxt[i];
      end
    end
  end

  // stage 3: rescale, saturate, sum of squares for normalize
  logic                s3_v_r;
  logic [SIDE_W-1:0]   s3_side_r;
  logic [PW-1:0]       s3_sum_r;
  logic [SIDE_W-1:0]   s3_side_nxt;
  logic [PW-1:0]       s3_sum_nxt;

  always_comb begin
    logic signed [XW-1:0] w;
    logic signed [XW-1:0] e0;
    logic signed [XW-1:0] e1;
    logic [W:0]           sr;
    logic                 ovf;
    logic                 norm;
    ovf  = 1'b0;
    norm = (s2_kind_r == KIND_NORM);
    s3_side_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      e0 = XW'(s2_p0_r[i]);
      e1 = XW'(s2_p1_r[i]);
      case (s2_kind_r) inside
        KIND_ADD, KIND_SUB:   w = XW'(s2_as_r[i]);
        KIND_MUL, KIND_SCALE: w = e0 >>> F;
        KIND_CROSS:           w = (e0 - e1) >>> F;
        default:              w = '0;
      endcase
      sr = sat_f(SW'(w));
      ovf = ovf | sr[W];
      if (norm) begin
        s3_side_nxt[i*W +: W] = s2_a_r[i];
      end else begin
        s3_side_nxt[i*W +: W] = sr[W-1:0];
      end
    end
    s3_side_nxt[3*W]   = norm ? 1'b0 : ovf;
    s3_side_nxt[3*W+1] = norm;
    s3_sum_nxt = $unsigned(s2_p0_r[0]) + $unsigned(s2_p0_r[1]) + $unsigned(s2_p0_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s3_side_nxt;
      s3_sum_r  <= s3_sum_nxt;
    end
  end

  // length, then reciprocal of length
  logic              sq_v;
  logic [W-1:0]      sq_root;
  logic [SIDE_W-1:0] sq_side;
  logic              dv_v;
  logic [Q-1:0]      dv_q;
  logic [W-1:0]      dv_len;
  logic [SIDE_W-1:0] dv_side;

  v3n_sqrt_pipe #(
    .W      (W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_n      (s3_sum_r),
    .in_side   (s3_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  v3n_recip_pipe #(
    .W      (W),
    .F      (F),
    .SIDE_W (SIDE_W)
  ) u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_len    (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_len   (dv_len),
    .out_side  (dv_side)
  );

  // stage m: component times reciprocal
  logic                 m_v_r;
  logic [SIDE_W-1:0]    m_side_r;
  logic                 m_zero_r;
  logic signed [MW-1:0] m_prod_r [3];
  logic signed [MW-1:0] m_prod_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_prod_nxt[i] = MW'($signed(dv_side[i*W +: W])) * $signed({1'b0, dv_q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side_r <= dv_side;
      m_zero_r <= (dv_len == '0);
      for (int i = 0; i < 3; i++) begin
        m_prod_r[i] <= m_prod_nxt[i];
      end
    end
  end

  // output register
  logic signed [W-1:0] out_r_r [3];
  logic                out_ovf_r;
  logic [W-1:0]        out_r_nxt [3];
  logic                out_ovf_nxt;

  always_comb begin
    logic signed [MW-1:0] sh;
    logic [W:0]           sr;
    out_ovf_nxt = m_side_r[3*W];
    for (int i = 0; i < 3; i++) begin
      sh = m_prod_r[i] >>> F;
      sr = sat_f(SW'(sh));
      if (m_side_r[3*W+1] && !m_zero_r) begin
        out_r_nxt[i] = sr[W-1:0];
        out_ovf_nxt  = out_ovf_nxt | sr[W];
      end else begin
        out_r_nxt[i] = m_side_r[i*W +: W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ovf_r <= out_ovf_nxt;
      for (int i = 0; i < 3; i++) begin
        out_r_r[i] <= out_r_nxt[i];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_r_x      = out_r_r[0];
  assign out_r_y      = out_r_r[1];
  assign out_r_z      = out_r_r[2];
  assign out_overflow = out_ovf_r;

  a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output beat held");

  a_front_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1_v_r))
    else $error("front stage moved during stall");

  a_zero_len : assert property (@(posedge clk) disable iff (!rst_n)
    (m_v_r && m_side_r[3*W+1] && m_zero_r) |-> !m_side_r[3*W])
    else $error("zero-length normalize carries overflow");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import v3n_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 120;
  localparam int LONG_HOLD = 400;
  localparam int MAX_IDLE = 11;

  // codes the unit treats as no operation
  localparam kind_t KIND_SPARE_LO = 3'd6;
  localparam kind_t KIND_SPARE_HI = 3'd7;

  localparam logic [DW-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [DW-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [DW-1:0] Q_MONE = 32'hFFFF_0000;
  localparam logic [DW-1:0] Q_LSB  = 32'h0000_0001;
  localparam logic [DW-1:0] Q_MLSB = 32'hFFFF_FFFF;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    kind_t             kind;
    logic [2:0][DW-1:0] a;
    logic [2:0][DW-1:0] b;
    logic [DW-1:0]      scale;
  } vec_beat_t;

  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] z;
    logic          ovf;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_stall;
  kind_t         in_kind = KIND_ADD;
  logic [DW-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic [DW-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic [DW-1:0] in_scale = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [DW-1:0] out_r_x, out_r_y, out_r_z;
  logic          out_overflow;

  vec_result_t result_q[$];
  int  error_count = 0;
  int  beats_sent = 0;
  int  beats_checked = 0;
  int  ovf_seen = 0;
  int  cycle_count = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  bit  hold_request = 1'b0;

  vector3_alu_with_normalize_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_a_x      (in_a_x),
    .in_a_y      (in_a_y),
    .in_a_z      (in_a_z),
    .in_b_x      (in_b_x),
    .in_b_y      (in_b_y),
    .in_b_z      (in_b_z),
    .in_scale    (in_scale),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_r_x     (out_r_x),
    .out_r_y     (out_r_y),
    .out_r_z     (out_r_z),
    .out_overflow(out_overflow)
  );

  // clock and watchdog
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, result_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // arithmetic helpers, exact in 128 bits
  function automatic wide_t widen(logic [DW-1:0] v);
    widen = {{(128-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic [DW-1:0] clamp(wide_t v, inout logic ovf);
    wide_t hi, lo;
    hi = widen(Q_MAX);
    lo = widen(Q_MIN);
    if (v > hi) begin
      ovf = 1'b1;
      clamp = Q_MAX;
    end else if (v < lo) begin
      ovf = 1'b1;
      clamp = Q_MIN;
    end else begin
      clamp = v[DW-1:0];
    end
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0] r, t;
    r = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      t = r | (64'd1 << bit_i);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    floor_sqrt = r;
  endfunction

  // expected outcome of one beat
  function automatic vec_result_t vector_unit_result(vec_beat_t bt);
    wide_t w[3];
    wide_t sum, recip;
    logic [63:0] len;
    logic ovf;
    vec_result_t r;
    int j, k;
    ovf = 1'b0;
    for (int i = 0; i < 3; i++) w[i] = '0;
    case (bt.kind)
      KIND_ADD: begin
        for (int i = 0; i < 3; i++) w[i] = widen(bt.a[i]) + widen(bt.b[i]);
      end
      KIND_SUB: begin
        for (int i = 0; i < 3; i++) w[i] = widen(bt.a[i]) - widen(bt.b[i]);
      end
      KIND_MUL: begin
        for (int i = 0; i < 3; i++) w[i] = (widen(bt.a[i]) * widen(bt.b[i])) >>> FB;
      end
      KIND_SCALE: begin
        for (int i = 0; i < 3; i++) w[i] = (widen(bt.a[i]) * widen(bt.scale)) >>> FB;
      end
      KIND_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          w[i] = (widen(bt.a[j]) * widen(bt.b[k]) - widen(bt.a[k]) * widen(bt.b[j])) >>> FB;
        end
      end
      KIND_NORM: begin
        sum = '0;
        for (int i = 0; i < 3; i++) sum = sum + widen(bt.a[i]) * widen(bt.a[i]);
        len = floor_sqrt(sum);
        if (len == 0) begin
          for (int i = 0; i < 3; i++) w[i] = widen(bt.a[i]);
        end else begin
          recip = (128'sd1 <<< (2 * FB)) / $signed({64'd0, len});
          for (int i = 0; i < 3; i++) w[i] = (widen(bt.a[i]) * recip) >>> FB;
        end
      end
      default: ;
    endcase
    r.x = clamp(w[0], ovf);
    r.y = clamp(w[1], ovf);
    r.z = clamp(w[2], ovf);
    r.ovf = ovf;
    return r;
  endfunction

  // packed index 0 is x
  function automatic vec_beat_t make_beat(kind_t kd, logic [DW-1:0] ax, logic [DW-1:0] ay,
                                          logic [DW-1:0] az, logic [DW-1:0] bx,
                                          logic [DW-1:0] by, logic [DW-1:0] bz,
                                          logic [DW-1:0] sc);
    vec_beat_t bt;
    bt.kind = kd;
    bt.a = {az, ay, ax};
    bt.b = {bz, by, bx};
    bt.scale = sc;
    return bt;
  endfunction

  // component drawn from a mix of magnitudes
  function automatic logic [DW-1:0] rand_comp();
    logic [DW-1:0] v;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 32'h3FFFF) - 32'h20000;
      3: begin
        case ($urandom_range(0, 6))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = Q_ONE;
          4: v = Q_MONE;
          5: v = Q_LSB;
          default: v = Q_MLSB;
        endcase
      end
      4: v = $urandom_range(0, 32'h00FF_FFFF);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  function automatic vec_beat_t rand_beat();
    kind_t kd;
    vec_beat_t bt;
    if ($urandom_range(0, 19) == 0) kd = ($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO;
    else kd = kind_t'($urandom_range(0, 5));
    bt = make_beat(kd, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp());
    // occasional all-zero vector for normalize
    if (kd == KIND_NORM && $urandom_range(0, 15) == 0) bt.a = '0;
    return bt;
  endfunction

  // send one beat, prediction taken at acceptance
  task automatic send_beat(vec_beat_t bt);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= bt.kind;
    in_a_x   <= bt.a[0];
    in_a_y   <= bt.a[1];
    in_a_z   <= bt.a[2];
    in_b_x   <= bt.b[0];
    in_b_y   <= bt.b[1];
    in_b_z   <= bt.b[2];
    in_scale <= bt.scale;
    do @(posedge clk); while (in_stall);
    result_q.push_back(vector_unit_result(bt));
    beats_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // receiver: stall pattern and result check
  initial begin
    vec_result_t exp_r;
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_request) n = LONG_HOLD;
      else n = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        hold_request = 1'b0;
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (result_q.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected: x=%h y=%h z=%h ovf=%b", $time,
                 out_r_x, out_r_y, out_r_z, out_overflow);
      end else begin
        exp_r = result_q.pop_front();
        beats_checked++;
        if (exp_r.ovf) ovf_seen++;
        if (out_r_x !== exp_r.x) begin
          error_count++;
          $display("%0t: r_x expected %h actual %h", $time, exp_r.x, out_r_x);
        end
        if (out_r_y !== exp_r.y) begin
          error_count++;
          $display("%0t: r_y expected %h actual %h", $time, exp_r.y, out_r_y);
        end
        if (out_r_z !== exp_r.z) begin
          error_count++;
          $display("%0t: r_z expected %h actual %h", $time, exp_r.z, out_r_z);
        end
        if (out_overflow !== exp_r.ovf) begin
          error_count++;
          $display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, out_overflow);
        end
      end
    end
  end

  // corner values for every operation
  task automatic test_directed();
    send_beat(make_beat(KIND_ADD, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MIN, Q_MONE, '0));
    send_beat(make_beat(KIND_ADD, Q_MAX, Q_MAX, '0, Q_LSB, Q_MLSB, '0, '0));
    send_beat(make_beat(KIND_SUB, Q_MIN, Q_MAX, '0, Q_LSB, Q_MLSB, Q_MIN, Q_MAX));
    send_beat(make_beat(KIND_SUB, Q_ONE, '0, Q_MLSB, Q_ONE, Q_MIN, Q_MLSB, '0));
    send_beat(make_beat(KIND_MUL, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '0));
    send_beat(make_beat(KIND_MUL, Q_MLSB, Q_LSB, Q_ONE, Q_LSB, Q_ONE, Q_MONE, '0));
    send_beat(make_beat(KIND_SCALE, Q_MAX, Q_MIN, Q_MLSB, '0, '0, '0, Q_MIN));
    send_beat(make_beat(KIND_SCALE, Q_ONE, Q_MONE, Q_LSB, '1, '1, '1, Q_MONE));
    send_beat(make_beat(KIND_SCALE, Q_MAX, Q_MLSB, Q_ONE, '0, '0, '0, Q_MAX));
    send_beat(make_beat(KIND_CROSS, Q_ONE, '0, '0, '0, Q_ONE, '0, '0));
    send_beat(make_beat(KIND_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, '0));
    send_beat(make_beat(KIND_CROSS, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '0));
    // zero-length vector comes back unchanged
    send_beat(make_beat(KIND_NORM, '0, '0, '0, Q_MAX, Q_MIN, Q_MAX, Q_MAX));
    send_beat(make_beat(KIND_NORM, Q_LSB, '0, '0, '0, '0, '0, '0));
    send_beat(make_beat(KIND_NORM, Q_MLSB, Q_LSB, Q_MLSB, '0, '0, '0, '0));
    send_beat(make_beat(KIND_NORM, Q_MAX, Q_MAX, Q_MAX, '0, '0, '0, '0));
    send_beat(make_beat(KIND_NORM, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0));
    send_beat(make_beat(KIND_NORM, Q_MONE, '0, '0, '0, '0, '0, '0));
    send_beat(make_beat(KIND_NORM, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0));
    // spare codes give zero
    send_beat(make_beat(KIND_SPARE_LO, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MIN, Q_ONE, Q_MAX));
    send_beat(make_beat(KIND_SPARE_HI, '1, '1, '1, '1, '1, '1, '1));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_beat(rand_beat());
  endtask

  // long receiver hold while the sender keeps offering beats
  task automatic test_backpressure();
    send_idle = 1'b0;
    hold_request = 1'b1;
    test_random(200);
    send_idle = 1'b1;
  endtask

  // sender waits for the pipeline to empty, then restarts
  task automatic test_drain_pause();
    test_random(40);
    stop_sending();
    wait_drained();
    test_random(40);
  endtask

  task automatic test_full_rate();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(250);
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed();
    test_random(500);
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    test_random(400);
    stop_sending();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d beats, %0d results checked, %0d with saturation", beats_sent,
             beats_checked, ovf_seen);
    $display("all kinds incl. spare codes, long output hold, drain pause, full-rate stretch");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
